FILE: rtl/pli_pkg.sv
// Shared constants, types and status codes for the positional list block.
package pli_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 13;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } pli_status_t;

    // Shift command broadcast to every cell in the row.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } pli_shift_t;

endpackage

FILE: rtl/pli_cell.sv
// One storage cell of the list row: holds a single entry and shifts with its neighbors.
module pli_cell (
    input  logic                      aclk,
    input  pli_pkg::pli_shift_t       shift_cmd,
    input  logic [pli_pkg::IDX_W-1:0] cell_idx,
    input  logic [pli_pkg::DATA_W-1:0] left_data,
    input  logic [pli_pkg::DATA_W-1:0] right_data,
    output logic [pli_pkg::DATA_W-1:0] data_out,
    output logic [pli_pkg::DATA_W-1:0] sel_data
);
    import pli_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_idx;
    logic              above_idx;

    assign at_idx    = (cell_idx == shift_cmd.idx);
    assign above_idx = (cell_idx > shift_cmd.idx);

    always_comb begin
        data_next = data_reg;
        if (shift_cmd.ins) begin
            if (at_idx) begin
                data_next = shift_cmd.value;
            end else if (above_idx) begin
                data_next = left_data;
            end
        end else if (shift_cmd.del) begin
            if (at_idx || above_idx) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    // Only the addressed cell drives its word onto the removal bus.
    assign sel_data = at_idx ? data_reg : '0;

endmodule

FILE: rtl/positional_list_insert_delete.sv
// Top level of the positional list: handshake, range checks, entry count and the row of cells.
//
// This block keeps an ordered list of up to DEPTH (64) signed 32-bit words. Each input word
// either inserts a value at a 1-based position, moving every later entry up one place, or
// deletes the entry at a position, moving every later entry down one place and returning the
// removed value. An insert position outside 1..count+1 or a delete position outside 1..count
// returns bad-position status and leaves the list untouched; a valid insert into a full list
// returns list-full status. Every input word produces exactly one result word carrying the
// status, the removed value (zero unless a delete succeeded) and the entry count after the
// operation. The list lives in a row of identical cells that all shift in the same clock
// edge. A new word is accepted every cycle as long as the single output register is empty
// or being drained, giving a sustained rate of one item per clock, and the result appears
// on m_tvalid in the cycle after acceptance.
// Entry contents need no reset; only the count and the handshake state are cleared.
module positional_list_insert_delete (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [12:0] position, [44:13] value, [47:45] zero
    input  logic [pli_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] func
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] removed_value, [44:32] count, [47:45] zero
    output logic [pli_pkg::M_DATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [pli_pkg::STATUS_W-1:0]  m_tuser
);
    import pli_pkg::*;

    // Input word fields.
    logic              in_func;
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_value;

    assign in_func  = s_tuser[0];
    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W +: DATA_W];

    // Control state.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Result register; payload needs no reset.
    pli_status_t       out_status_reg;
    logic [DATA_W-1:0] out_removed_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic accept;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Range checks. The count is widened to the position width before comparing.
    logic [POS_W-1:0] count_ext;
    logic             pos_nonzero;
    logic             ins_pos_ok;
    logic             del_pos_ok;
    logic             list_full;
    logic             ins_ok;
    logic             del_ok;
    pli_status_t      status;

    assign count_ext   = POS_W'(count_reg);
    assign pos_nonzero = (in_pos != '0);
    assign ins_pos_ok  = pos_nonzero && (in_pos <= count_ext + POS_W'(1));
    assign del_pos_ok  = pos_nonzero && (in_pos <= count_ext);
    assign list_full   = (count_reg == CNT_W'(DEPTH));
    assign ins_ok      = (in_func == OP_INSERT) && ins_pos_ok && !list_full;
    assign del_ok      = (in_func == OP_DELETE) && del_pos_ok;

    always_comb begin
        if (in_func == OP_INSERT) begin
            if (!ins_pos_ok) begin
                status = ST_BADPOS;
            end else if (list_full) begin
                status = ST_FULL;
            end else begin
                status = ST_DONE;
            end
        end else begin
            status = del_pos_ok ? ST_DONE : ST_BADPOS;
        end
    end

    // Shift command for the row; it only fires on an accepted, valid operation.
    pli_shift_t shift_cmd;
    logic [POS_W-1:0] pos_m1;

    assign pos_m1          = in_pos - POS_W'(1);
    assign shift_cmd.ins   = accept && ins_ok;
    assign shift_cmd.del   = accept && del_ok;
    assign shift_cmd.idx   = pos_m1[IDX_W-1:0];
    assign shift_cmd.value = in_value;

    // The row of cells. Each cell sees its two neighbors; the ends see zero.
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_sel  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_data[i+1];
        end

        pli_cell u_cell (
            .aclk       (aclk),
            .shift_cmd  (shift_cmd),
            .cell_idx   (IDX_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .data_out   (cell_data[i]),
            .sel_data   (cell_sel[i])
        );
    end

    // Exactly one cell matches the index, so an OR of the masked words gives the removed entry.
    logic [DATA_W-1:0] sel_or;
    always_comb begin
        sel_or = '0;
        for (int j = 0; j < DEPTH; j++) begin
            sel_or = sel_or | cell_sel[j];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (accept && ins_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (accept && del_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg  <= status;
            out_removed_reg <= del_ok ? sel_or : '0;
            out_count_reg   <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(M_DATA_W - DATA_W - COUNT_W)'(0),
                       COUNT_W'(out_count_reg), out_removed_reg};

    // The entry count never passes the list depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond list depth");

    // A successful insert grows the list by exactly one entry.
    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ins_ok |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list by one");

    // A successful delete shrinks the list by exactly one entry.
    a_del_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && del_ok |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink the list by one");

    // A rejected operation reports no removed value.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_DONE) |-> m_tdata[DATA_W-1:0] == '0)
        else $error("rejected operation reports a removed value");

endmodule
